@@ hw/rtl/i2cm_pkg.sv @@
// Package for the I2C master bit engine: beat payload structs, command codes,
// register indexes and the one-hot phase encoding.
// No dependencies; imported by every RTL module of the engine.
package i2cm_pkg;

    localparam int FUNC_W = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 16;

    // Command codes carried in func.
    localparam logic [FUNC_W-1:0] FUNC_NONE  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_STOP  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_HALF_BIT_TICKS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WAIT_LIMIT     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACK_POLLS      = 2'd2;

    localparam logic [15:0] HALF_BIT_TICKS_RST = 16'd250;
    localparam logic [15:0] WAIT_LIMIT_RST     = 16'd1000;
    localparam logic [7:0]  ACK_POLLS_RST      = 8'd10;

    typedef struct packed {
        logic [15:0] half_bit_ticks;
        logic [15:0] wait_limit;
        logic [7:0]  ack_polls;
    } t_cfg;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [7:0]        tx_byte;
        logic              last_read;
        logic              scl_level;
        logic              sda_level;
    } t_in_item;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       done_res;
        logic       ok;
        logic [7:0] rx_byte;
    } t_res_item;

    typedef enum logic [21:0] {
        PH_IDLE    = 22'd1 << 0,
        PH_ST_D1   = 22'd1 << 1,
        PH_ST_WSDA = 22'd1 << 2,
        PH_ST_WSCL = 22'd1 << 3,
        PH_ST_D2   = 22'd1 << 4,
        PH_SP_D1   = 22'd1 << 5,
        PH_SP_D2   = 22'd1 << 6,
        PH_SP_WSCL = 22'd1 << 7,
        PH_SP_D3   = 22'd1 << 8,
        PH_SP_WSDA = 22'd1 << 9,
        PH_RD_WSCL = 22'd1 << 10,
        PH_RD_D0   = 22'd1 << 11,
        PH_RD_HIA  = 22'd1 << 12,
        PH_RD_HIB  = 22'd1 << 13,
        PH_RD_LOA  = 22'd1 << 14,
        PH_RD_LOB  = 22'd1 << 15,
        PH_RD_ACK  = 22'd1 << 16,
        PH_WR_WSDA = 22'd1 << 17,
        PH_WR_LO   = 22'd1 << 18,
        PH_WR_HI   = 22'd1 << 19,
        PH_WR_AD   = 22'd1 << 20,
        PH_WR_POLL = 22'd1 << 21
    } t_phase;

endpackage

@@ hw/rtl/i2c_master_bit_engine.sv @@
// Top level of the I2C master bit engine: input beat register, sequencer,
// configuration registers and output beat register.
// Depends on i2cm_pkg, i2cm_cfg_regs and i2cm_fsm.

// Each input beat is one tick of bus timing: it carries the sampled SCL and
// SDA levels and, while the engine is idle, a command (start, stop, write
// byte, read byte). Every input beat yields exactly one output beat with the
// line drives, busy, done, ok and the received byte. The engine takes one
// beat per clock while the output side is not stalled; a beat is registered
// on entry, stepped through the sequencer once the output register is free
// and held in the output register until taken. The input register stalls
// only while it holds a beat that cannot step, so a new beat is still taken
// while a finished result waits on the output side and the input is empty.
// Configuration registers may be written only while no beat is in flight.
module i2c_master_bit_engine
    import i2cm_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [2:0] func, [10:3] tx_byte, [11] last_read, [12] scl_level,
    // [13] sda_level, [15:14] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] scl_pull_low, [1] sda_pull_low, [2] busy_res, [3] done_res,
    // [4] ok, [12:5] rx_byte, [15:13] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg      cfg;
    t_in_item  in_item;
    t_res_item res;

    logic                  r_in_v;
    logic [IN_TDATA_W-1:0] r_in;
    logic                  r_out_v;
    t_res_item             r_out;
    logic                  step;
    logic                  s_acc;

    assign step          = r_in_v && (!r_out_v || m_axis_tready);
    assign s_axis_tready = !r_in_v || step;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    assign in_item.func      = r_in[2:0];
    assign in_item.tx_byte   = r_in[10:3];
    assign in_item.last_read = r_in[11];
    assign in_item.scl_level = r_in[12];
    assign in_item.sda_level = r_in[13];

    i2cm_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    i2cm_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (in_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s_acc) begin
                r_in_v <= 1'b1;
            end else if (step) begin
                r_in_v <= 1'b0;
            end
            if (step) begin
                r_out_v <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in <= s_axis_tdata;
        end
        if (step) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {3'd0, r_out.rx_byte, r_out.ok, r_out.done_res,
                            r_out.busy_res, r_out.sda_pull_low, r_out.scl_pull_low};

endmodule

@@ hw/rtl/i2cm_cfg_regs.sv @@
// Configuration registers of the I2C master bit engine: bit delay, wait
// limit and acknowledge poll count. Depends on i2cm_pkg.
module i2cm_cfg_regs
    import i2cm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_bit_ticks <= HALF_BIT_TICKS_RST;
            r_cfg.wait_limit     <= WAIT_LIMIT_RST;
            r_cfg.ack_polls      <= ACK_POLLS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_HALF_BIT_TICKS: r_cfg.half_bit_ticks <= i_cfg_data;
                CFG_WAIT_LIMIT:     r_cfg.wait_limit <= i_cfg_data;
                CFG_ACK_POLLS:      r_cfg.ack_polls <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/i2cm_fsm.sv @@
// Bus sequencer of the I2C master bit engine: phase register, counters,
// shift register and line drives, advanced by one tick per step.
// Depends on i2cm_pkg.
module i2cm_fsm
    import i2cm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_res_item o_res
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_delay, n_delay;
    logic [15:0] r_wait, n_wait;
    logic [7:0]  r_poll, n_poll;
    logic        r_nack, n_nack;
    logic        r_scl, n_scl;
    logic        r_sda, n_sda;

    logic [15:0] d_inc, w_inc;
    logic [7:0]  p_inc;
    logic [2:0]  bit_dec;
    logic        d_over, w_fail, p_done;
    logic        fin, okv, rxv;

    always_comb begin
        d_inc   = r_delay + 16'd1;
        w_inc   = r_wait + 16'd1;
        p_inc   = r_poll + 8'd1;
        bit_dec = r_bit - 3'd1;
        d_over  = d_inc >= i_cfg.half_bit_ticks;
        w_fail  = w_inc >= i_cfg.wait_limit;
        p_done  = p_inc >= i_cfg.ack_polls;

        n_phase = r_phase;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_delay = r_delay;
        n_wait  = r_wait;
        n_poll  = r_poll;
        n_nack  = r_nack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        fin     = 1'b0;
        okv     = 1'b0;
        rxv     = 1'b0;

        case (r_phase)
            PH_IDLE: begin
                case (i_item.func)
                    FUNC_START: begin
                        n_scl   = 1'b1;
                        n_phase = PH_ST_D1;
                        n_delay = '0;
                    end
                    FUNC_STOP: begin
                        n_scl   = 1'b1;
                        n_phase = PH_SP_D1;
                        n_delay = '0;
                    end
                    FUNC_WRITE: begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b0;
                        n_shift = i_item.tx_byte;
                        n_phase = PH_WR_WSDA;
                        n_wait  = '0;
                    end
                    FUNC_READ: begin
                        n_scl   = 1'b0;
                        n_nack  = i_item.last_read;
                        n_phase = PH_RD_WSCL;
                        n_wait  = '0;
                    end
                    default: ;
                endcase
            end
            PH_ST_D1: begin
                n_delay = d_inc;
                if (d_over) begin
                    n_sda   = 1'b0;
                    n_phase = PH_ST_WSDA;
                    n_wait  = '0;
                end
            end
            PH_ST_WSDA: begin
                if (i_item.sda_level) begin
                    n_scl   = 1'b0;
                    n_phase = PH_ST_WSCL;
                    n_wait  = '0;
                end else begin
                    n_wait = w_inc;
                    fin    = w_fail;
                end
            end
            PH_ST_WSCL: begin
                if (i_item.scl_level) begin
                    n_sda   = 1'b1;
                    n_phase = PH_ST_D2;
                    n_delay = '0;
                end else begin
                    n_wait = w_inc;
                    fin    = w_fail;
                end
            end
            PH_ST_D2: begin
                n_delay = d_inc;
                fin     = d_over;
                okv     = d_over;
            end
            PH_SP_D1: begin
                n_delay = d_inc;
                if (d_over) begin
                    n_sda   = 1'b1;
                    n_phase = PH_SP_D2;
                    n_delay = '0;
                end
            end
            PH_SP_D2: begin
                n_delay = d_inc;
                if (d_over) begin
                    n_scl   = 1'b0;
                    n_phase = PH_SP_WSCL;
                    n_wait  = '0;
                end
            end
            PH_SP_WSCL: begin
                if (i_item.scl_level) begin
                    n_sda   = 1'b0;
                    n_phase = PH_SP_D3;
                    n_delay = '0;
                end else begin
                    n_wait = w_inc;
                    fin    = w_fail;
                end
            end
            PH_SP_D3: begin
                n_delay = d_inc;
                if (d_over) begin
                    n_phase = PH_SP_WSDA;
                    n_wait  = '0;
                end
            end
            PH_SP_WSDA: begin
                if (i_item.sda_level) begin
                    fin = 1'b1;
                    okv = 1'b1;
                end else begin
                    n_wait = w_inc;
                    fin    = w_fail;
                end
            end
            PH_RD_WSCL: begin
                if (i_item.scl_level) begin
                    n_scl   = 1'b1;
                    n_phase = PH_RD_D0;
                    n_delay = '0;
                end else begin
                    n_wait = w_inc;
                    fin    = w_fail;
                end
            end
            PH_RD_D0: begin
                n_delay = d_inc;
                if (d_over) begin
                    n_sda   = 1'b0;
                    n_scl   = 1'b0;
                    n_shift = '0;
                    n_bit   = 3'd7;
                    n_phase = PH_RD_HIA;
                    n_delay = '0;
                end
            end
            PH_RD_HIA: begin
                n_delay = d_inc;
                if (d_over) begin
                    n_phase = PH_RD_HIB;
                    n_delay = '0;
                end
            end
            PH_RD_HIB: begin
                n_delay = d_inc;
                if (d_over) begin
                    n_shift = r_shift | ({7'd0, i_item.sda_level} << r_bit);
                    n_scl   = 1'b1;
                    n_phase = PH_RD_LOA;
                    n_delay = '0;
                end
            end
            PH_RD_LOA: begin
                n_delay = d_inc;
                if (d_over) begin
                    n_phase = PH_RD_LOB;
                    n_delay = '0;
                end
            end
            PH_RD_LOB: begin
                n_delay = d_inc;
                if (d_over) begin
                    n_delay = '0;
                    if (r_bit == 3'd0) begin
                        // Drive low for ACK, release for NACK.
                        n_sda   = ~r_nack;
                        n_phase = PH_RD_ACK;
                    end else begin
                        n_bit   = bit_dec;
                        n_scl   = 1'b0;
                        n_phase = PH_RD_HIA;
                    end
                end
            end
            PH_RD_ACK: begin
                n_delay = d_inc;
                if (d_over) begin
                    n_scl = 1'b0;
                    fin   = 1'b1;
                    okv   = 1'b1;
                    rxv   = 1'b1;
                end
            end
            PH_WR_WSDA: begin
                if (i_item.sda_level) begin
                    n_bit   = 3'd7;
                    n_scl   = 1'b1;
                    n_sda   = ~r_shift[7];
                    n_phase = PH_WR_LO;
                    n_delay = '0;
                end else begin
                    n_wait = w_inc;
                    fin    = w_fail;
                end
            end
            PH_WR_LO: begin
                n_delay = d_inc;
                if (d_over) begin
                    n_scl   = 1'b0;
                    n_phase = PH_WR_HI;
                    n_delay = '0;
                end
            end
            PH_WR_HI: begin
                n_delay = d_inc;
                if (d_over) begin
                    n_delay = '0;
                    if (r_bit == 3'd0) begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b0;
                        n_phase = PH_WR_AD;
                    end else begin
                        n_bit   = bit_dec;
                        n_scl   = 1'b1;
                        n_sda   = ~r_shift[bit_dec];
                        n_phase = PH_WR_LO;
                    end
                end
            end
            PH_WR_AD: begin
                n_delay = d_inc;
                if (d_over) begin
                    n_scl   = 1'b0;
                    n_poll  = '0;
                    n_phase = PH_WR_POLL;
                    n_delay = '0;
                end
            end
            PH_WR_POLL: begin
                n_delay = d_inc;
                if (d_over) begin
                    if (!i_item.sda_level) begin
                        n_sda = 1'b1;
                        fin   = 1'b1;
                        okv   = 1'b1;
                    end else begin
                        n_poll = p_inc;
                        if (p_done) begin
                            n_sda = 1'b1;
                            fin   = 1'b1;
                        end else begin
                            n_delay = '0;
                        end
                    end
                end
            end
            default: n_phase = PH_IDLE;
        endcase

        if (fin) begin
            n_phase = PH_IDLE;
        end

        o_res.scl_pull_low = n_scl;
        o_res.sda_pull_low = n_sda;
        o_res.busy_res     = n_phase != PH_IDLE;
        o_res.done_res     = fin;
        o_res.ok           = okv;
        o_res.rx_byte      = rxv ? r_shift : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= '0;
            r_shift <= '0;
            r_delay <= '0;
            r_wait  <= '0;
            r_poll  <= '0;
            r_nack  <= 1'b0;
            r_scl   <= 1'b0;
            r_sda   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_delay <= n_delay;
            r_wait  <= n_wait;
            r_poll  <= n_poll;
            r_nack  <= n_nack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
        end
    end

endmodule
